/* src/mksg_pkg.sv */
package mksg_pkg;

    localparam int CODE_BITS = 32;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = $clog2(CODE_BITS + 1);
    localparam int CFG_W     = 16;
    localparam int PROD_W    = LEN_W + CFG_W;
    localparam int COUNT_W   = 13;
    localparam int ACC_W     = 24;
    localparam int IDX_W     = 8;
    localparam int FRAC_W    = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_W-1:0] DPS_RESET = CFG_W'(5243);
    localparam logic [CFG_W-1:0] SPD_RESET = CFG_W'(3200);

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    typedef enum logic {
        REG_DITS_PER_SAMPLE = 1'b0,
        REG_SAMPLES_PER_DIT = 1'b1
    } t_reg_index;

    typedef struct packed {
        t_func                func;
        logic [LEN_W-1:0]     len;
        logic [CODE_BITS-1:0] code;
    } t_norm_item;

    function automatic logic [CODE_BITS-1:0] fit_code(input logic [CODE_W-1:0] code);
        logic [CODE_BITS-1:0] c;
        c = '0;
        for (int i = 0; i < CODE_BITS; i++) begin
            if (i < CODE_W) begin
                c[i] = code[i % CODE_W];
            end
        end
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] code_len(input logic [CODE_BITS-1:0] c);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < CODE_BITS; i++) begin
            if (c[i]) begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

/* src/morse_keying_sample_generator_unit.sv */
// Morse keying sample generator. Each input item is either a load (tuser 0), which takes a
// Morse element code from tdata, strips its leading zeros and sizes the sample count as
// elements times samples_per_dit_q8, or a tick (tuser 1), which gives one key sample and
// advances the Q8.16 dit accumulator by dits_per_sample_q16 while samples remain. Every
// item yields exactly one result item. The block takes one item per clock while the output
// is not stalled; a result item passes an input register, a leading-zero strip stage and
// the state update stage whose result register feeds the output, and the state update
// closes its loop on its own registers. Configuration writes are always ready and must
// only be made while no items are in flight.
module morse_keying_sample_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [mksg_pkg::CODE_W-1:0]       i_s_tdata,  // code
    input  logic                              i_s_tuser,  // func
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [mksg_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // sample, samples_left, active, pad
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [mksg_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [mksg_pkg::CFG_W-1:0] r_dps;
    logic [mksg_pkg::CFG_W-1:0] r_spd;

    logic                       norm_valid;
    logic                       core_ready;
    mksg_pkg::t_norm_item       norm_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dps <= mksg_pkg::DPS_RESET;
            r_spd <= mksg_pkg::SPD_RESET;
        end else if (i_cfg_valid) begin
            unique case (mksg_pkg::t_reg_index'(i_cfg_index))
                mksg_pkg::REG_DITS_PER_SAMPLE: r_dps <= i_cfg_data;
                mksg_pkg::REG_SAMPLES_PER_DIT: r_spd <= i_cfg_data;
                default: r_dps <= r_dps;
            endcase
        end
    end

    mksg_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_func  (mksg_pkg::t_func'(i_s_tuser)),
        .i_code  (i_s_tdata),
        .o_valid (norm_valid),
        .i_ready (core_ready),
        .o_item  (norm_item)
    );

    mksg_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (norm_valid),
        .o_ready    (core_ready),
        .i_item     (norm_item),
        .i_dps      (r_dps),
        .i_spd      (r_spd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

/* src/mksg_norm.sv */
module mksg_norm (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  mksg_pkg::t_func         i_func,
    input  logic [mksg_pkg::CODE_W-1:0] i_code,
    output logic                    o_valid,
    input  logic                    i_ready,
    output mksg_pkg::t_norm_item    o_item
);

    logic                              r_a_valid;
    mksg_pkg::t_func                   r_a_func;
    logic [mksg_pkg::CODE_BITS-1:0]    r_a_code;
    logic                              r_b_valid;
    mksg_pkg::t_norm_item              r_b_item;

    logic                              b_free;
    logic [mksg_pkg::LEN_W-1:0]        len;
    logic [mksg_pkg::LEN_W-1:0]        shamt;
    mksg_pkg::t_norm_item              n_b_item;

    assign b_free  = !r_b_valid || i_ready;
    assign o_ready = !r_a_valid || b_free;

    // leading zero removal
    always_comb begin
        len   = mksg_pkg::code_len(r_a_code);
        shamt = mksg_pkg::LEN_W'(mksg_pkg::CODE_BITS) - len;
        n_b_item.func = r_a_func;
        n_b_item.len  = len;
        n_b_item.code = r_a_code << shamt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_func <= i_func;
            r_a_code <= mksg_pkg::fit_code(i_code);
        end
        if (b_free && r_a_valid) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

/* src/mksg_core.sv */
module mksg_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  mksg_pkg::t_norm_item         i_item,
    input  logic [mksg_pkg::CFG_W-1:0]   i_dps,
    input  logic [mksg_pkg::CFG_W-1:0]   i_spd,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [mksg_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    logic [mksg_pkg::CODE_BITS-1:0] r_shift, n_shift;
    logic [mksg_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [mksg_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic [mksg_pkg::IDX_W-1:0]     r_idx, n_idx;

    logic                           r_out_valid;
    logic                           r_sample, n_sample;
    logic [mksg_pkg::COUNT_W-1:0]   r_left;
    logic                           r_active;

    logic                           take;
    logic [mksg_pkg::PROD_W-1:0]    prod;
    logic [mksg_pkg::ACC_W-1:0]     acc_sum;

    assign o_ready = !r_out_valid || i_m_tready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_shift  = r_shift;
        n_count  = r_count;
        n_acc    = r_acc;
        n_idx    = r_idx;
        n_sample = 1'b0;
        prod     = mksg_pkg::PROD_W'(i_item.len) * mksg_pkg::PROD_W'(i_spd);
        acc_sum  = r_acc + mksg_pkg::ACC_W'(i_dps);
        unique case (i_item.func)
            mksg_pkg::FUNC_LOAD: begin
                n_shift = i_item.code;
                n_acc   = '0;
                n_idx   = '0;
                // sample count saturates at its top value
                if (|prod[mksg_pkg::PROD_W-1:mksg_pkg::COUNT_W+8]) begin
                    n_count = mksg_pkg::COUNT_MAX;
                end else begin
                    n_count = prod[mksg_pkg::COUNT_W+7:8];
                end
            end
            mksg_pkg::FUNC_TICK: begin
                if (r_count != '0) begin
                    n_sample = r_shift[mksg_pkg::CODE_BITS-1];
                    n_acc    = acc_sum;
                    if (acc_sum[mksg_pkg::ACC_W-1:mksg_pkg::FRAC_W] != r_idx) begin
                        n_idx   = r_idx + 1'b1;
                        n_shift = r_shift << 1;
                    end
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_sample = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_count     <= '0;
            r_acc       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_shift <= n_shift;
                r_count <= n_count;
                r_acc   <= n_acc;
                r_idx   <= n_idx;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample <= n_sample;
            r_left   <= n_count;
            r_active <= (n_count != '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = mksg_pkg::OUT_DATA_W'({r_active, r_left, r_sample});

    a_idx_tracks_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx == r_acc[mksg_pkg::ACC_W-1:mksg_pkg::FRAC_W])
        else $error("dit index out of step with accumulator");

    a_count_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.func == mksg_pkg::FUNC_TICK && r_count != '0
        |=> r_count == $past(r_count) - 1'b1)
        else $error("sample count did not step down on a tick");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.func == mksg_pkg::FUNC_TICK && r_count == '0
        |=> $stable(r_shift) && $stable(r_acc) && r_count == '0)
        else $error("state moved on a tick after the code finished");

    a_active_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_active == (r_left != '0))
        else $error("active flag disagrees with samples left");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_count == '0 |=> !r_sample)
        else $error("key on with no samples remaining");

endmodule
